[rtl/wgta_pkg.sv]
`timescale 1ns / 1ps
package wgta_pkg;
    localparam int MAX_TRACKS = 16;
    localparam int MAX_LIMBO  = 16;
    localparam int ID_BITS    = 16;
    localparam int TIDX_W     = $clog2(MAX_TRACKS);
    localparam int LIDX_W     = $clog2(MAX_LIMBO);
    localparam int TCNT_W     = $clog2(MAX_TRACKS + 1);
    localparam int LCNT_W     = $clog2(MAX_LIMBO + 1);
    localparam int WIN_W      = 12;
    localparam int COORD_W    = 16;
    localparam int POS_W      = 2 * COORD_W;
    localparam int CNT_OUT_W  = 5;

    localparam logic [1:0] MODE_DET   = 2'd0;
    localparam logic [1:0] MODE_EOF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic [2:0] SRC_NEW     = 3'd0;
    localparam logic [2:0] SRC_LIMBO   = 3'd1;
    localparam logic [2:0] SRC_CONT    = 3'd2;
    localparam logic [2:0] SRC_DROPPED = 3'd3;
    localparam logic [2:0] SRC_CTRL    = 3'd4;

    localparam logic REG_WINDOW_X = 1'b0;
    localparam logic REG_WINDOW_Y = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [ID_BITS-1:0] ident;
    } entry_t;
endpackage

[rtl/wgta_near.sv]
`timescale 1ns / 1ps
// Shared gate compare: both axes strictly inside the half window.
module wgta_near (
    input  logic [wgta_pkg::POS_W-1:0] pos_a,
    input  logic [wgta_pkg::POS_W-1:0] pos_b,
    input  logic [wgta_pkg::WIN_W-1:0] window_x,
    input  logic [wgta_pkg::WIN_W-1:0] window_y,
    output logic                       hit
);
    logic [15:0] ax, bx, ay, by, dx, dy;
    logic [15:0] hx, hy;

    always_comb begin
        ax = pos_a[31:16];
        bx = pos_b[31:16];
        ay = pos_a[15:0];
        by = pos_b[15:0];
        dx = (ax > bx) ? (ax - bx) : (bx - ax);
        dy = (ay > by) ? (ay - by) : (by - ay);
        hx = {1'b0, window_x[11:1], 4'b0000};
        hy = {1'b0, window_y[11:1], 4'b0000};
        hit = (dx < hx) && (dy < hy);
    end
endmodule

[rtl/window_gated_track_association.sv]
`timescale 1ns / 1ps
// Window gated track association.
// Input channel s_*: mode, det_x, det_y (Q12.4). Mode 0 associates a
// detection, mode 1 closes a frame, mode 2 clears all tables.
// Result channel m_*: track_id, source, moved_to_limbo, limbo_dropped; one
// item per input item, held in an output register until taken.
// Config port: cfg_we / cfg_index / cfg_data writes window_x (0) or
// window_y (1); write only while idle.
// Sequencing: one gate compare unit is shared under a sequencer. A detection
// searches limbo, then, without a limbo hit, the previous list; a match is
// taken out of its list by a compaction shift of one entry per cycle, then
// the detection is appended to the current list. End of frame tests each
// previous entry against the current list, then copies the current list
// into the previous one at one entry per cycle. Clear, the unused mode and
// a detection into a full current list go straight to the result register.
// s_ready is low while an item is at work or a result waits unaccepted.
// Reset empties all lists, zeroes the identifier counter, sets both
// windows to 64; table contents stay undefined until written.
module window_gated_track_association (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_det_x,
    input  logic [15:0] s_det_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_track_id,
    output logic [2:0]  m_source,
    output logic [4:0]  m_moved_to_limbo,
    output logic [4:0]  m_limbo_dropped,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LSRCH  = 4'd1;
    localparam logic [3:0] ST_PSRCH  = 4'd2;
    localparam logic [3:0] ST_LSHIFT = 4'd3;
    localparam logic [3:0] ST_PSHIFT = 4'd4;
    localparam logic [3:0] ST_APPEND = 4'd5;
    localparam logic [3:0] ST_EPREV  = 4'd6;
    localparam logic [3:0] ST_ECUR   = 4'd7;
    localparam logic [3:0] ST_ECOPY  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    localparam int TW = wgta_pkg::TIDX_W;
    localparam int LW = wgta_pkg::LIDX_W;
    localparam int TC = wgta_pkg::TCNT_W;
    localparam int LC = wgta_pkg::LCNT_W;

    wgta_pkg::entry_t cur_mem   [wgta_pkg::MAX_TRACKS];
    wgta_pkg::entry_t prev_mem  [wgta_pkg::MAX_TRACKS];
    wgta_pkg::entry_t limbo_mem [wgta_pkg::MAX_LIMBO];

    logic [3:0]  state_reg;
    logic [TC-1:0] cur_cnt_reg, prev_cnt_reg;
    logic [LC-1:0] limbo_cnt_reg;
    logic [wgta_pkg::ID_BITS-1:0] next_id_reg;
    logic [11:0] win_x_reg, win_y_reg;
    logic [TC-1:0] i_reg;   // list walk index (counts)
    logic [TC-1:0] j_reg;   // current list index at end of frame
    logic [wgta_pkg::POS_W-1:0] pos_reg;
    logic [wgta_pkg::ID_BITS-1:0] id_reg;
    logic [2:0]  src_reg;
    logic [4:0]  moved_reg, dropped_reg;
    logic        m_valid_reg;

    logic [wgta_pkg::POS_W-1:0] cmp_b, cmp_a;
    logic cmp_hit;
    logic [TW-1:0] ti, ti1, tj, tcopy;
    logic [LW-1:0] li, li1;

    assign ti  = i_reg[TW-1:0];
    assign ti1 = TW'(i_reg + TC'(1));
    assign li  = LW'(i_reg);
    assign li1 = LW'(i_reg + TC'(1));
    assign tj  = j_reg[TW-1:0];
    assign tcopy = j_reg[TW-1:0];

    always_comb begin
        cmp_a = pos_reg;
        case (state_reg)
            ST_LSRCH: cmp_b = limbo_mem[li].pos;
            ST_PSRCH: cmp_b = prev_mem[ti].pos;
            ST_ECUR:  cmp_b = cur_mem[tj].pos;
            default:  cmp_b = prev_mem[ti].pos;
        endcase
    end

    wgta_near u_near (
        .pos_a(cmp_a), .pos_b(cmp_b),
        .window_x(win_x_reg), .window_y(win_y_reg), .hit(cmp_hit)
    );

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_track_id = id_reg;
    assign m_source = src_reg;
    assign m_moved_to_limbo = moved_reg;
    assign m_limbo_dropped = dropped_reg;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_x_reg <= 12'd64;
            win_y_reg <= 12'd64;
        end else if (cfg_we) begin
            if (cfg_index == wgta_pkg::REG_WINDOW_X) win_x_reg <= cfg_data;
            else win_y_reg <= cfg_data;
        end
    end

    // Table storage, written only by the sequencer
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_LSHIFT: limbo_mem[li] <= limbo_mem[li1];
            ST_PSHIFT: prev_mem[ti] <= prev_mem[ti1];
            ST_APPEND: cur_mem[cur_cnt_reg[TW-1:0]] <= '{pos: pos_reg, ident: id_reg};
            ST_ECUR: begin
                if (!cmp_hit && (j_reg + TC'(1) >= cur_cnt_reg)
                        && (limbo_cnt_reg < LC'(wgta_pkg::MAX_LIMBO)))
                    limbo_mem[limbo_cnt_reg[LW-1:0]] <= prev_mem[ti];
            end
            ST_EPREV: begin
                // entry under test is i_reg-1
                if (i_reg != '0 && cur_cnt_reg == '0
                        && limbo_cnt_reg < LC'(wgta_pkg::MAX_LIMBO))
                    limbo_mem[limbo_cnt_reg[LW-1:0]] <= prev_mem[TW'(i_reg - TC'(1))];
            end
            ST_ECOPY: prev_mem[tcopy] <= cur_mem[tcopy];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_cnt_reg <= '0;
            prev_cnt_reg <= '0;
            limbo_cnt_reg <= '0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        pos_reg <= {s_det_x, s_det_y};
                        id_reg <= '0;
                        src_reg <= wgta_pkg::SRC_CTRL;
                        moved_reg <= '0;
                        dropped_reg <= '0;
                        i_reg <= '0;
                        j_reg <= '0;
                        case (s_mode)
                            wgta_pkg::MODE_DET: begin
                                if (cur_cnt_reg >= TC'(wgta_pkg::MAX_TRACKS)) begin
                                    src_reg <= wgta_pkg::SRC_DROPPED;
                                    state_reg <= ST_OUT;
                                end else begin
                                    state_reg <= ST_LSRCH;
                                end
                            end
                            wgta_pkg::MODE_EOF: begin
                                i_reg <= prev_cnt_reg;
                                state_reg <= ST_EPREV;
                            end
                            wgta_pkg::MODE_CLEAR: begin
                                cur_cnt_reg <= '0;
                                prev_cnt_reg <= '0;
                                limbo_cnt_reg <= '0;
                                next_id_reg <= '0;
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_LSRCH: begin
                    if (TC'(i_reg) >= TC'(limbo_cnt_reg)) begin
                        i_reg <= '0;
                        state_reg <= ST_PSRCH;
                    end else if (cmp_hit) begin
                        id_reg <= limbo_mem[li].ident;
                        src_reg <= wgta_pkg::SRC_LIMBO;
                        state_reg <= ST_LSHIFT;
                    end else begin
                        i_reg <= i_reg + TC'(1);
                    end
                end
                ST_PSRCH: begin
                    if (i_reg >= prev_cnt_reg) begin
                        id_reg <= next_id_reg;
                        src_reg <= wgta_pkg::SRC_NEW;
                        next_id_reg <= next_id_reg + wgta_pkg::ID_BITS'(1);
                        state_reg <= ST_APPEND;
                    end else if (cmp_hit) begin
                        id_reg <= prev_mem[ti].ident;
                        src_reg <= wgta_pkg::SRC_CONT;
                        state_reg <= ST_PSHIFT;
                    end else begin
                        i_reg <= i_reg + TC'(1);
                    end
                end
                ST_LSHIFT: begin
                    // shift one entry down per cycle, then shrink
                    if (TC'(i_reg) + TC'(1) >= TC'(limbo_cnt_reg)) begin
                        limbo_cnt_reg <= limbo_cnt_reg - LC'(1);
                        state_reg <= ST_APPEND;
                    end else begin
                        i_reg <= i_reg + TC'(1);
                    end
                end
                ST_PSHIFT: begin
                    if (i_reg + TC'(1) >= prev_cnt_reg) begin
                        prev_cnt_reg <= prev_cnt_reg - TC'(1);
                        state_reg <= ST_APPEND;
                    end else begin
                        i_reg <= i_reg + TC'(1);
                    end
                end
                ST_APPEND: begin
                    cur_cnt_reg <= cur_cnt_reg + TC'(1);
                    state_reg <= ST_OUT;
                end
                ST_EPREV: begin
                    // i_reg counts down; entry under test is i_reg-1
                    if (i_reg == '0) begin
                        j_reg <= '0;
                        state_reg <= ST_ECOPY;
                    end else begin
                        i_reg <= i_reg - TC'(1);
                        pos_reg <= prev_mem[TW'(i_reg - TC'(1))].pos;
                        j_reg <= '0;
                        if (cur_cnt_reg != '0) state_reg <= ST_ECUR;
                        else if (limbo_cnt_reg < LC'(wgta_pkg::MAX_LIMBO)) begin
                            state_reg <= ST_EPREV;
                        end
                    end
                    // empty current list: straight to limbo, dropped if limbo full
                    if (i_reg != '0 && cur_cnt_reg == '0) begin
                        if (limbo_cnt_reg < LC'(wgta_pkg::MAX_LIMBO)) begin
                            limbo_cnt_reg <= limbo_cnt_reg + LC'(1);
                            if (moved_reg != 5'd31) moved_reg <= moved_reg + 5'd1;
                        end else if (dropped_reg != 5'd31) begin
                            dropped_reg <= dropped_reg + 5'd1;
                        end
                    end
                end
                ST_ECUR: begin
                    if (cmp_hit) begin
                        state_reg <= ST_EPREV;
                    end else if (j_reg + TC'(1) >= cur_cnt_reg) begin
                        if (limbo_cnt_reg < LC'(wgta_pkg::MAX_LIMBO)) begin
                            limbo_cnt_reg <= limbo_cnt_reg + LC'(1);
                            if (moved_reg != 5'd31) moved_reg <= moved_reg + 5'd1;
                        end else if (dropped_reg != 5'd31) begin
                            dropped_reg <= dropped_reg + 5'd1;
                        end
                        state_reg <= ST_EPREV;
                    end else begin
                        j_reg <= j_reg + TC'(1);
                    end
                end
                ST_ECOPY: begin
                    if (j_reg >= cur_cnt_reg) begin
                        prev_cnt_reg <= cur_cnt_reg;
                        cur_cnt_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        j_reg <= j_reg + TC'(1);
                    end
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // pos_reg holds the entry under test at end of frame; in EPREV the mux
    // reads prev_mem[ti] (entry i_reg, unused), ECUR compares pos_reg.

    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_cnt_reg <= TC'(wgta_pkg::MAX_TRACKS))
        else $error("current count over capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        limbo_cnt_reg <= LC'(wgta_pkg::MAX_LIMBO))
        else $error("limbo count over capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("ready while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_valid_reg)
        else $error("result lost");
endmodule

[verif/track_checker.sv]
`timescale 1ns / 1ps
module track_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_det_x,
    input  logic [15:0] s_det_y,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_track_id,
    input  logic [2:0]  m_source,
    input  logic [4:0]  m_moved_to_limbo,
    input  logic [4:0]  m_limbo_dropped,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  src;
        logic [4:0]  moved;
        logic [4:0]  dropped;
    } verdict_t;

    verdict_t verdicts[$];
    logic [11:0] gate_x, gate_y;
    logic [wgta_pkg::POS_W-1:0] cur_p[wgta_pkg::MAX_TRACKS], prev_p[wgta_pkg::MAX_TRACKS];
    logic [wgta_pkg::POS_W-1:0] limbo_p[wgta_pkg::MAX_LIMBO];
    logic [wgta_pkg::ID_BITS-1:0] cur_i[wgta_pkg::MAX_TRACKS], prev_i[wgta_pkg::MAX_TRACKS];
    logic [wgta_pkg::ID_BITS-1:0] limbo_i[wgta_pkg::MAX_LIMBO];
    int n_cur, n_prev, n_limbo;
    logic [wgta_pkg::ID_BITS-1:0] fresh_id;

    assign pending = verdicts.size();

    function automatic logic gated(logic [wgta_pkg::POS_W-1:0] a,
                                   logic [wgta_pkg::POS_W-1:0] b);
        logic [16:0] hx, hy, dx, dy;
        hx = {5'd0, gate_x >> 1} << 4;
        hy = {5'd0, gate_y >> 1} << 4;
        dx = {1'b0, (a[31:16] > b[31:16]) ? a[31:16] - b[31:16] : b[31:16] - a[31:16]};
        dy = {1'b0, (a[15:0] > b[15:0]) ? a[15:0] - b[15:0] : b[15:0] - a[15:0]};
        return (dx < hx) && (dy < hy);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Advance the association state by one item; return its verdict.
    task automatic associate(logic [1:0] mode, logic [wgta_pkg::POS_W-1:0] pos,
                             output verdict_t v);
        int hit, k;
        logic found;
        v = '0;
        v.src = wgta_pkg::SRC_CTRL;
        if (mode == wgta_pkg::MODE_DET) begin
            if (n_cur >= wgta_pkg::MAX_TRACKS) begin
                v.src = wgta_pkg::SRC_DROPPED;
            end else begin
                hit = -1;
                for (k = 0; k < n_limbo; k++)
                    if (hit < 0 && gated(pos, limbo_p[k])) hit = k;
                if (hit >= 0) begin
                    v.id = limbo_i[hit];
                    v.src = wgta_pkg::SRC_LIMBO;
                    for (k = hit; k + 1 < n_limbo; k++) begin
                        limbo_p[k] = limbo_p[k+1];
                        limbo_i[k] = limbo_i[k+1];
                    end
                    n_limbo--;
                end else begin
                    for (k = 0; k < n_prev; k++)
                        if (hit < 0 && gated(pos, prev_p[k])) hit = k;
                    if (hit >= 0) begin
                        v.id = prev_i[hit];
                        v.src = wgta_pkg::SRC_CONT;
                        for (k = hit; k + 1 < n_prev; k++) begin
                            prev_p[k] = prev_p[k+1];
                            prev_i[k] = prev_i[k+1];
                        end
                        n_prev--;
                    end else begin
                        v.id = fresh_id;
                        v.src = wgta_pkg::SRC_NEW;
                        fresh_id++;
                    end
                end
                cur_p[n_cur] = pos;
                cur_i[n_cur] = v.id;
                n_cur++;
            end
        end else if (mode == wgta_pkg::MODE_EOF) begin
            // Walk the previous list from its end; unmatched tracks go to limbo, or count as dropped when it is full.
            for (int i = n_prev - 1; i >= 0; i--) begin
                found = 1'b0;
                for (k = 0; k < n_cur; k++)
                    if (gated(prev_p[i], cur_p[k])) found = 1'b1;
                if (!found) begin
                    if (n_limbo < wgta_pkg::MAX_LIMBO) begin
                        limbo_p[n_limbo] = prev_p[i];
                        limbo_i[n_limbo] = prev_i[i];
                        n_limbo++;
                        if (v.moved < 31) v.moved++;
                    end else if (v.dropped < 31) begin
                        v.dropped++;
                    end
                end
            end
            prev_p = cur_p;
            prev_i = cur_i;
            n_prev = n_cur;
            n_cur = 0;
        end else if (mode == wgta_pkg::MODE_CLEAR) begin
            n_cur = 0;
            n_prev = 0;
            n_limbo = 0;
            fresh_id = '0;
        end
    endtask

    always @(posedge aclk) begin
        verdict_t v, got;
        if (!aresetn) begin
            gate_x <= 12'd64;
            gate_y <= 12'd64;
            n_cur = 0;
            n_prev = 0;
            n_limbo = 0;
            fresh_id = '0;
            verdicts.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == wgta_pkg::REG_WINDOW_X) gate_x <= cfg_data;
                else gate_y <= cfg_data;
            end
            if (m_valid && m_ready) begin
                got = {m_track_id, m_source, m_moved_to_limbo, m_limbo_dropped};
                if (verdicts.size() == 0) begin
                    $display("MISMATCH unexpected result item at %0t", $realtime);
                    fail_count++;
                end else begin
                    v = verdicts.pop_front();
                    if (got.id != v.id) report("track_id", got.id, v.id);
                    if (got.src != v.src) report("source", got.src, v.src);
                    if (got.moved != v.moved) report("moved_to_limbo", got.moved, v.moved);
                    if (got.dropped != v.dropped)
                        report("limbo_dropped", got.dropped, v.dropped);
                end
            end
            if (s_valid && s_ready) begin
                associate(s_mode, {s_det_x, s_det_y}, v);
                verdicts = {verdicts, v};
            end
        end
    end
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0, s_ready;
    logic [1:0]  s_mode = wgta_pkg::MODE_DET;
    logic [15:0] s_det_x = '0, s_det_y = '0;
    logic        m_valid, m_ready = 1'b0;
    logic [15:0] m_track_id;
    logic [2:0]  m_source;
    logic [4:0]  m_moved_to_limbo, m_limbo_dropped;
    logic        cfg_we = 1'b0;
    logic        cfg_index = wgta_pkg::REG_WINDOW_X;
    logic [11:0] cfg_data = '0;
    int          fail_count, pending;
    int          idle_cycles = 0;
    int          sent = 0, frames = 0;
    logic        calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    window_gated_track_association i_dut (.*);
    track_checker i_chk (.*);

    // Receiver: stall in random bursts, none during the calm tail.
    initial begin : sink
        int burst;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Send one item; hold valid and payload until accepted.
    task automatic send(logic [1:0] mode, logic [15:0] x, logic [15:0] y);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_det_x <= x;
        s_det_y <= y;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (mode == wgta_pkg::MODE_EOF) frames++;
    endtask

    // Drop valid, drain every result, then let the sequencer settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_gates(logic [11:0] wx, logic [11:0] wy);
        cfg_we <= 1'b1;
        cfg_index <= wgta_pkg::REG_WINDOW_X;
        cfg_data <= wx;
        @(posedge aclk);
        cfg_index <= wgta_pkg::REG_WINDOW_Y;
        cfg_data <= wy;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Hold eight track spots and jitter detections around them across frames.
    task automatic run_frames(int count, int spread);
        logic [15:0] bx[8], by[8];
        int k, n;
        for (k = 0; k < 8; k++) begin
            bx[k] = 16'($urandom);
            by[k] = 16'($urandom);
        end
        for (int f = 0; f < count; f++) begin
            n = $urandom_range(0, 18);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(0, 19))
                    0: send(wgta_pkg::MODE_RSVD, 16'($urandom), 16'($urandom));
                    1: send(wgta_pkg::MODE_DET, 16'($urandom), 16'($urandom));
                    default: send(wgta_pkg::MODE_DET,
                                  16'(bx[k%8] + $urandom_range(0, spread) - spread/2),
                                  16'(by[k%8] + $urandom_range(0, spread) - spread/2));
                endcase
            end
            send(wgta_pkg::MODE_EOF, 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 40) == 0)
                send(wgta_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, revival, continuation, clear and unused mode.
        send(wgta_pkg::MODE_DET, 16'h0000, 16'h0000);
        send(wgta_pkg::MODE_DET, 16'hFFFF, 16'hFFFF);
        send(wgta_pkg::MODE_DET, 16'h0010, 16'h0010);
        send(wgta_pkg::MODE_EOF, 16'h0000, 16'h0000);
        send(wgta_pkg::MODE_DET, 16'hFFF0, 16'hFFF0);
        send(wgta_pkg::MODE_EOF, 16'hFFFF, 16'hFFFF);
        send(wgta_pkg::MODE_DET, 16'h0000, 16'h0000);
        send(wgta_pkg::MODE_RSVD, 16'hFFFF, 16'h0000);
        send(wgta_pkg::MODE_CLEAR, 16'h0000, 16'hFFFF);
        // Fill the current list past full.
        for (int k = 0; k < 17; k++) send(wgta_pkg::MODE_DET, 16'(k * 16'h0F00), 16'h1234);
        send(wgta_pkg::MODE_EOF, 16'h0, 16'h0);
        send(wgta_pkg::MODE_EOF, 16'h0, 16'h0);
        drain();

        // Random: vary the gates between phases, zero and full among them.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_gates(12'd0, 12'd4095);
                1: write_gates(12'd4095, 12'd4095);
                2: write_gates(12'd1, 12'd2);
                3: write_gates(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
                default: write_gates(12'($urandom_range(8, 300)), 12'($urandom_range(8, 300)));
            endcase
            if (ph == 5) calm = 1'b1;
            while (sent < 40 + (ph + 1) * RANDOM_ITEMS / 6)
                run_frames(1, (ph == 3) ? 16'hFFFF : 2000);
            drain();
        end

        $display("Sent %0d items over %0d frames under six gate settings", sent, frames);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[files.f]
rtl/wgta_pkg.sv
rtl/wgta_near.sv
rtl/window_gated_track_association.sv
verif/track_checker.sv
verif/testbench.sv
